// File: rtl/bavf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bavf_pkg;

    localparam logic [7:0] VENDOR_TYPE  = 8'hFF;
    localparam logic [3:0] VENDOR_BYTES = 4'd12;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_TYPE = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] device_id;
        logic [15:0] food;
        logic [15:0] furnace;
        logic [15:0] battery;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/bavf_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module bavf_walker
    import bavf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    [7:0] i_byte,
    input  wire logic    i_last,
    output t_result      o_result
);

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_left,    n_left;
    logic [3:0]  r_offset,  n_offset;
    logic        r_inv,     n_inv;
    logic        r_seen,    n_seen;
    logic [1:0]  r_status,  n_status;
    logic [47:0] r_id,      n_id;
    logic [15:0] r_food,    n_food;
    logic [15:0] r_furnace, n_furnace;
    logic [15:0] r_battery, n_battery;
    logic [7:0]  w_left_dec;

    assign w_left_dec = r_left - 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_offset  = r_offset;
        n_inv     = r_inv;
        n_seen    = r_seen;
        n_status  = r_status;
        n_id      = r_id;
        n_food    = r_food;
        n_furnace = r_furnace;
        n_battery = r_battery;

        unique case (r_phase)
            PH_TYPE: begin
                if (i_byte == VENDOR_TYPE && !r_seen) begin
                    n_seen   = 1'b1;
                    n_inv    = 1'b1;
                    n_offset = 4'd0;
                    n_status = ST_TRUNC;
                end
                if (r_left == 8'd0) begin
                    n_phase = PH_LEN;
                    n_inv   = 1'b0;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_inv) begin
                    case (r_offset)
                        4'd0:    n_id[47:40]       = i_byte;
                        4'd1:    n_id[39:32]       = i_byte;
                        4'd2:    n_id[31:24]       = i_byte;
                        4'd3:    n_id[23:16]       = i_byte;
                        4'd4:    n_id[15:8]        = i_byte;
                        4'd5:    n_id[7:0]         = i_byte;
                        4'd6:    n_food[7:0]       = i_byte;
                        4'd7:    n_food[15:8]      = i_byte;
                        4'd8:    n_furnace[7:0]    = i_byte;
                        4'd9:    n_furnace[15:8]   = i_byte;
                        4'd10:   n_battery[7:0]    = i_byte;
                        4'd11:   n_battery[15:8]   = i_byte;
                        default: n_id              = r_id;
                    endcase
                    if (r_offset < VENDOR_BYTES) begin
                        n_offset = r_offset + 4'd1;
                        if (r_offset + 4'd1 == VENDOR_BYTES) begin
                            n_status = ST_DONE;
                        end
                    end
                end
                // A data phase is only entered with bytes still to come.
                if (r_left != 8'd0) begin
                    n_left = w_left_dec;
                end
                if (r_left <= 8'd1) begin
                    n_phase = PH_LEN;
                    n_inv   = 1'b0;
                end
            end
            default: begin
                if (i_byte != 8'd0) begin
                    n_left  = i_byte - 8'd1;
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_LEN;
                end
            end
        endcase
    end

    assign o_result.status     = n_status;
    assign o_result.device_id  = n_id;
    assign o_result.food       = n_food;
    assign o_result.furnace    = n_furnace;
    assign o_result.battery    = n_battery;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase   <= PH_LEN;
            r_left    <= 8'd0;
            r_offset  <= 4'd0;
            r_inv     <= 1'b0;
            r_seen    <= 1'b0;
            r_status  <= ST_NONE;
            r_id      <= 48'd0;
            r_food    <= 16'd0;
            r_furnace <= 16'd0;
            r_battery <= 16'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_offset  <= n_offset;
            r_inv     <= n_inv;
            r_seen    <= n_seen;
            r_status  <= n_status;
            r_id      <= n_id;
            r_food    <= n_food;
            r_furnace <= n_furnace;
            r_battery <= n_battery;
        end
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != 8'd0)
        else $error("data phase with no bytes left");

    a_vendor_implies_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inv |-> r_seen)
        else $error("vendor field open without a vendor type byte");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= VENDOR_BYTES)
        else $error("vendor offset beyond field length");

endmodule

`default_nettype wire

// File: rtl/ble_advert_vendor_field_extractor.sv
`timescale 1ns / 1ps
`default_nettype none

// One payload byte is taken per cycle; the block sustains one transfer per clock
// while the final byte is not waiting for room in the output register. A byte is held
// in an input register and walked through the parser when it steps. The result is
// loaded into the output register as the final byte steps, and is offered from there.
// Synchronous active-low reset returns the parser to expect a length byte and
// empties both the input and the output register.

module ble_advert_vendor_field_extractor
    import bavf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire logic  [7:0] i_ad_byte,
    input  wire logic  i_end_of_advert,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [1:0]  o_parse_status,
    output logic [47:0] o_device_id,
    output logic [15:0] o_probe_temp,
    output logic [15:0] o_oven_temp,
    output logic [15:0] o_supply_volts
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_result    w_res;
    logic       w_out_free;
    logic       w_step;

    assign w_out_free = !r_out_valid || i_out_ready;
    // Only the final byte needs room in the output register.
    assign w_step     = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_ready = !r_in_valid || w_step;

    bavf_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_ad_byte;
            r_in_last <= i_end_of_advert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parse_status = r_res.status;
    assign o_device_id    = r_res.device_id;
    assign o_probe_temp   = r_res.food;
    assign o_oven_temp    = r_res.furnace;
    assign o_supply_volts = r_res.battery;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_step && r_in_last))
        else $error("result offered without a final byte");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_in_last |=> o_out_valid)
        else $error("final byte produced no result");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled byte lost from input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_in_last |-> w_out_free)
        else $error("result register overwritten before transfer");

endmodule

`default_nettype wire
